>>> src/xrp_pkg.sv
// Shared types, codes and helpers for the X authority record parser.
`timescale 1ns / 1ps
package xrp_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int OFS_W  = 32;
  localparam int ST_W   = 3;

  typedef enum logic [13:0] {
    PH_FAM0   = 14'h0001,
    PH_FAM1   = 14'h0002,
    PH_ALEN_H = 14'h0004,
    PH_ALEN_L = 14'h0008,
    PH_ADDR   = 14'h0010,
    PH_NLEN_H = 14'h0020,
    PH_NLEN_L = 14'h0040,
    PH_NUM    = 14'h0080,
    PH_MLEN_H = 14'h0100,
    PH_MLEN_L = 14'h0200,
    PH_NAME   = 14'h0400,
    PH_DLEN_H = 14'h0800,
    PH_DLEN_L = 14'h1000,
    PH_DATA   = 14'h2000
  } phase_t;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_END_ALEN = 3'd1;
  localparam logic [ST_W-1:0] ST_END_NLEN = 3'd2;
  localparam logic [ST_W-1:0] ST_END_MLEN = 3'd3;
  localparam logic [ST_W-1:0] ST_END_DLEN = 3'd4;
  localparam logic [ST_W-1:0] ST_END_DATA = 3'd5;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFS_W-1:0] name_offset;
    logic [LEN_W-1:0] name_length;
    logic [OFS_W-1:0] data_offset;
    logic [LEN_W-1:0] data_length;
    logic             last_result;
  } res_t;

  // Status for a file that ends with the parser in phase ph.
  function automatic logic [ST_W-1:0] end_status(phase_t ph);
    logic [ST_W-1:0] st;
    case (ph)
      PH_FAM0, PH_FAM1, PH_ALEN_H, PH_ALEN_L: st = ST_END_ALEN;
      PH_ADDR, PH_NLEN_H, PH_NLEN_L:          st = ST_END_NLEN;
      PH_NUM, PH_MLEN_H, PH_MLEN_L:           st = ST_END_MLEN;
      PH_NAME, PH_DLEN_H, PH_DLEN_L:          st = ST_END_DLEN;
      default:                                st = ST_END_DATA;
    endcase
    return st;
  endfunction

endpackage

>>> src/xrp_ifs.sv
// Stream interfaces: file bytes in, parse records out.
`timescale 1ns / 1ps
interface xrp_byte_if;
  import xrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface xrp_rec_if;
  import xrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [OFS_W-1:0] name_offset;
  logic [LEN_W-1:0] name_length;
  logic [OFS_W-1:0] data_offset;
  logic [LEN_W-1:0] data_length;
  logic             last_result;

  modport source (output valid, output status, output name_offset, output name_length,
                  output data_offset, output data_length, output last_result,
                  input ready);
  modport sink   (input valid, input status, input name_offset, input name_length,
                  input data_offset, input data_length, input last_result,
                  output ready);
endinterface

>>> src/xauthority_record_parser_unit.sv
// Top level of the X authority record parser: input register, parser and result buffer.
//
//   channel   dir   word                                               handshake
//   bytes     in    file_byte, end_of_file                             valid/ready
//   records   out   status, name/data offset and length, last_result   valid/ready
//
// One file byte is taken per clock while the result buffer has space and no held word waits;
// the parse state is registered from combinational next-state logic. A result passes
// through the input register, then the result buffer, before it is offered on records.
// A byte that closes a record and ends the file gives two words and holds input until the second is pushed.
// Synchronous reset returns the parse to the first family byte at offset zero.
// A stall on records backs up through the two-entry buffer into the input register.
`timescale 1ns / 1ps
module xauthority_record_parser_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  xrp_byte_if.sink  bytes,
  xrp_rec_if.source records
);
  import xrp_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eof;
  logic              take;
  logic              space;
  logic              emit_valid;
  res_t              emit_res;

  assign bytes.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.file_byte;
      in_eof  <= bytes.end_of_file;
    end
  end

  xrp_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_eof     (in_eof),
    .space      (space),
    .take       (take),
    .emit_valid (emit_valid),
    .emit_res   (emit_res)
  );

  xrp_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (emit_valid),
    .push_res (emit_res),
    .space    (space),
    .records  (records)
  );

endmodule

>>> src/xrp_parser.sv
// Record parse FSM: one byte per cycle unless stalled, up to two result words per byte.
`timescale 1ns / 1ps
module xrp_parser #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [xrp_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_eof,
  input  logic                      space,
  output logic                      take,
  output logic                      emit_valid,
  output xrp_pkg::res_t             emit_res
);
  import xrp_pkg::*;

  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] position, pos_inc;
  logic [LEN_W-1:0]       bytes_left, bytes_left_next, bytes_dec;
  logic [BYTE_W-1:0]      length_high, length_high_next;
  logic [OFS_W-1:0]       name_start, name_start_next, data_start, data_start_next;
  logic [LEN_W-1:0]       name_size, name_size_next, data_size, data_size_next;
  logic [LEN_W-1:0]       len;
  logic                   done;
  logic [ST_W-1:0]        eof_status;
  // second word of a byte that both closes a record and ends the file
  logic                   pend;
  logic [ST_W-1:0]        pend_status;

  assign len       = {length_high, in_byte};
  assign bytes_dec = bytes_left - LEN_W'(1);
  assign pos_inc   = (position == '1) ? position : position + OFFSET_BITS'(1);

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    length_high_next = length_high;
    name_start_next  = name_start;
    name_size_next   = name_size;
    data_start_next  = data_start;
    data_size_next   = data_size;
    done             = 1'b0;
    case (phase)
      PH_FAM0: phase_next = PH_FAM1;
      PH_FAM1: phase_next = PH_ALEN_H;
      PH_ALEN_H: begin
        length_high_next = in_byte;
        phase_next       = PH_ALEN_L;
      end
      PH_NLEN_H: begin
        length_high_next = in_byte;
        phase_next       = PH_NLEN_L;
      end
      PH_MLEN_H: begin
        length_high_next = in_byte;
        phase_next       = PH_MLEN_L;
      end
      PH_DLEN_H: begin
        length_high_next = in_byte;
        phase_next       = PH_DLEN_L;
      end
      PH_ALEN_L: begin
        bytes_left_next = len;
        phase_next      = (len != '0) ? PH_ADDR : PH_NLEN_H;
      end
      PH_NLEN_L: begin
        bytes_left_next = len;
        phase_next      = (len != '0) ? PH_NUM : PH_MLEN_H;
      end
      PH_MLEN_L: begin
        bytes_left_next = len;
        name_start_next = OFS_W'(pos_inc);
        name_size_next  = len;
        phase_next      = (len != '0) ? PH_NAME : PH_DLEN_H;
      end
      PH_DLEN_L: begin
        bytes_left_next = len;
        data_start_next = OFS_W'(pos_inc);
        data_size_next  = len;
        if (len != '0) begin
          phase_next = PH_DATA;
        end else begin
          done       = 1'b1;
          phase_next = PH_FAM0;
        end
      end
      PH_ADDR: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) phase_next = PH_NLEN_H;
      end
      PH_NUM: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) phase_next = PH_MLEN_H;
      end
      PH_NAME: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) phase_next = PH_DLEN_H;
      end
      PH_DATA: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) begin
          done       = 1'b1;
          phase_next = PH_FAM0;
        end
      end
      default: phase_next = PH_FAM0;
    endcase
  end

  assign eof_status = end_status(phase_next);
  assign take       = in_valid && !pend && space;
  assign emit_valid = space && (pend || (in_valid && (done || in_eof)));

  always_comb begin
    emit_res = '0;
    if (pend) begin
      emit_res.status      = pend_status;
      emit_res.last_result = 1'b1;
    end else if (done) begin
      emit_res.status      = ST_OK;
      emit_res.name_offset = name_start_next;
      emit_res.name_length = name_size_next;
      emit_res.data_offset = data_start_next;
      emit_res.data_length = data_size_next;
      emit_res.last_result = !in_eof;
    end else begin
      emit_res.status      = eof_status;
      emit_res.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FAM0;
      position    <= '0;
      bytes_left  <= '0;
      length_high <= '0;
      name_start  <= '0;
      name_size   <= '0;
      data_start  <= '0;
      data_size   <= '0;
      pend        <= 1'b0;
    end else begin
      if (take) begin
        if (in_eof) begin
          // end of file: next byte starts a fresh file at offset zero
          phase       <= PH_FAM0;
          position    <= '0;
          bytes_left  <= '0;
          length_high <= '0;
          name_start  <= '0;
          name_size   <= '0;
          data_start  <= '0;
          data_size   <= '0;
        end else begin
          phase       <= phase_next;
          position    <= pos_inc;
          bytes_left  <= bytes_left_next;
          length_high <= length_high_next;
          name_start  <= name_start_next;
          name_size   <= name_size_next;
          data_start  <= data_start_next;
          data_size   <= data_size_next;
        end
      end
      if (take && done && in_eof) begin
        pend <= 1'b1;
      end else if (pend && space) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && done && in_eof) pend_status <= eof_status;
  end

`ifndef SYNTH
  a_pend_from_eof: assert property (@(posedge clk) disable iff (rst)
    $rose(pend) |-> $past(take && in_eof && done))
    else $error("held word without a record closing on end of file");
  a_no_take_pend: assert property (@(posedge clk) disable iff (rst)
    pend |-> !take)
    else $error("byte taken while a held word waits");
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_eof |=> position == '0 && phase == PH_FAM0)
    else $error("state not cleared after end of file");
  a_pend_last: assert property (@(posedge clk) disable iff (rst)
    emit_valid && pend |-> emit_res.last_result && emit_res.status != ST_OK)
    else $error("held word is not a final end status");
`endif

endmodule

>>> src/xrp_out_fifo.sv
// Two-entry result buffer that drives the record output channel.
`timescale 1ns / 1ps
module xrp_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xrp_pkg::res_t push_res,
  output logic          space,
  xrp_rec_if.source     records
);
  import xrp_pkg::*;

  res_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;
  res_t       head;

  assign space = (count != 2'd2);
  assign pop   = records.valid && records.ready;
  assign head  = slot[rd_ptr];

  assign records.valid       = (count != 2'd0);
  assign records.status      = head.status;
  assign records.name_offset = head.name_offset;
  assign records.name_length = head.name_length;
  assign records.data_offset = head.data_offset;
  assign records.data_length = head.data_length;
  assign records.last_result = head.last_result;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("result pushed into a full buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    records.valid && !records.ready |=> records.valid && $stable(head))
    else $error("output word changed while stalled");
`endif

endmodule
